@@ hw/rtl/wec_pkg.sv @@
// Package for the window event coalescer: field widths, opcodes, result kinds.
// No dependencies.
`default_nettype none
package wec_pkg;
    localparam int unsigned WinW      = 32;
    localparam int unsigned FlagW     = 32;
    localparam int unsigned TickW     = 16;
    localparam int unsigned DepthDef  = 16;
    localparam logic [TickW-1:0] BatchReset = 16'd10;

    localparam logic [1:0] OpChange = 2'd0;
    localparam logic [1:0] OpRemove = 2'd1;
    localparam logic [1:0] OpAdd    = 2'd2;
    localparam logic [1:0] OpTick   = 2'd3;

    localparam logic [1:0] KindChange = 2'd0;
    localparam logic [1:0] KindRemove = 2'd1;
    localparam logic [1:0] KindAdd    = 2'd2;

    localparam logic [1:0] CfgMaskA = 2'd0;
    localparam logic [1:0] CfgMaskB = 2'd1;
    localparam logic [1:0] CfgBatch = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [WinW-1:0]  window_id;
        logic [FlagW-1:0] flags_a;
        logic [FlagW-1:0] flags_b;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [WinW-1:0]  out_window;
        logic [FlagW-1:0] out_flags_a;
        logic [FlagW-1:0] out_flags_b;
        logic             last;
    } t_out_item;
endpackage
`default_nettype wire

@@ hw/rtl/wec_in_if.sv @@
// Input channel interface carrying one event transaction.
// Depends on wec_pkg.
`default_nettype none
interface wec_in_if;
    import wec_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/wec_out_if.sv @@
// Output channel interface carrying one result transaction.
// Depends on wec_pkg.
`default_nettype none
interface wec_out_if;
    import wec_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/window_event_coalescer.sv @@
// Window event coalescer top level: pending table memory and sequencer.
// Depends on wec_pkg, wec_in_if and wec_out_if.
//
// Usage: events arrive as transactions on i_evt (opcode, window_id, flags_a,
// flags_b); results leave on o_res (kind, out_window, out_flags_a,
// out_flags_b, last). Configuration registers (cachable masks and batch
// length) are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// The pending table lives in one synchronous memory with a registered read
// port. Each change or removal is handled by a sequencer that scans every
// slot of that memory, one slot per cycle, to find the window and the lowest
// free slot. After the scan, a change to a window that already has an entry
// goes through S_DECIDE, S_RDSLOT and S_MERGE; every other change or removal
// finishes in S_DECIDE. Additions and ticks are handled in the idle state
// without a scan. A flush on timer expiry walks the table again, slot by
// slot, emitting each pending entry as one result transaction; the last
// one carries last = 1. Slot valid bits are flip-flops cleared by reset, so
// the table is empty at once after reset and no clearing pass is needed.
// Results sit in an output register; when the receiver stalls the
// sequencer waits, and no result is lost or repeated. A new event is taken
// only after every result of the previous one has been handed over.
`default_nettype none
module window_event_coalescer #(
    parameter int unsigned TABLE_DEPTH = wec_pkg::DepthDef
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    wec_in_if.sink                       i_evt,
    wec_out_if.source                    o_res,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [wec_pkg::FlagW-1:0] i_cfg_data
);
    import wec_pkg::*;

    localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RDSLOT, S_MERGE, S_FLUSH, S_EMIT
    } t_state;

    typedef struct packed {
        logic [WinW-1:0]  win;
        logic [FlagW-1:0] fa;
        logic [FlagW-1:0] fb;
    } t_slot;

    t_slot mem [TABLE_DEPTH];
    t_slot r_rd;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [FlagW-1:0] r_mask_a, r_mask_b;
    logic [TickW-1:0] r_batch, r_ticks;
    logic             r_armed;

    t_state         r_state;
    t_in_item       r_item;
    logic [CntW-1:0] r_idx;       // slot being issued to the memory
    logic [IdxW-1:0] r_rd_idx;    // slot whose data is in r_rd
    logic           r_rd_ok;
    logic           r_hit, r_free_ok;
    logic [IdxW-1:0] r_hit_idx, r_free_idx;
    logic           r_out_valid;
    t_out_item      r_out;

    // memory port controls
    logic           mem_we;
    logic [IdxW-1:0] mem_wa, mem_ra;
    t_slot          mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    logic cachable;
    assign cachable = ((r_item.flags_a & ~r_mask_a) == '0) &&
                      ((r_item.flags_b & ~r_mask_b) == '0);

    // Remaining valid slots above the one being flushed decide the last flag.
    logic [TABLE_DEPTH-1:0] above_mask;
    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            above_mask[k] = (k > int'(r_rd_idx));
        end
    end

    assign i_evt.ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    logic out_free;
    assign out_free = !r_out_valid || o_res.ready;

    // High when the sequencer loads a new result into the output register.
    logic out_load;
    always_comb begin
        case (r_state)
            S_IDLE:   out_load = i_evt.valid && i_evt.ready &&
                                 (i_evt.data.opcode == OpAdd);
            S_DECIDE: out_load = out_free && ((r_item.opcode == OpRemove) ||
                                 (!r_hit && !(cachable && r_free_ok)));
            S_MERGE:  out_load = out_free && !cachable;
            S_EMIT:   out_load = out_free;
            default:  out_load = 1'b0;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_hit_idx;
        mem_wd = '{win: r_item.window_id, fa: r_rd.fa | r_item.flags_a,
                   fb: r_rd.fb | r_item.flags_b};
        mem_ra = r_idx[IdxW-1:0];
        if (r_state == S_DECIDE && cachable && !r_hit && r_free_ok) begin
            mem_we = 1'b1;
            mem_wa = r_free_idx;
            mem_wd = '{win: r_item.window_id, fa: r_item.flags_a,
                       fb: r_item.flags_b};
        end else if (r_state == S_MERGE && cachable) begin
            mem_we = 1'b1;
        end
        // Keep the hit slot on the read port until the merge uses it.
        if (r_state == S_DECIDE || r_state == S_RDSLOT) begin
            mem_ra = r_hit_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_mask_a    <= '0;
            r_mask_b    <= '0;
            r_batch     <= BatchReset;
            r_ticks     <= '0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgMaskA: r_mask_a <= i_cfg_data;
                    CfgMaskB: r_mask_b <= i_cfg_data;
                    CfgBatch: r_batch  <= i_cfg_data[TickW-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx     <= '0;
                    r_rd_ok   <= 1'b0;
                    r_hit     <= 1'b0;
                    r_free_ok <= 1'b0;
                    if (i_evt.valid && i_evt.ready) begin
                        r_item <= i_evt.data;
                        case (i_evt.data.opcode)
                            OpAdd: begin
                                r_out       <= '{kind: KindAdd,
                                                 out_window: i_evt.data.window_id,
                                                 out_flags_a: '0, out_flags_b: '0,
                                                 last: 1'b1};
                            end
                            OpTick: begin
                                if (r_armed) begin
                                    if (r_ticks > TickW'(1)) begin
                                        r_ticks <= r_ticks - TickW'(1);
                                    end else begin
                                        r_ticks <= '0;
                                        r_armed <= 1'b0;
                                        r_state <= S_FLUSH;
                                    end
                                end
                            end
                            default: r_state <= S_SCAN;
                        endcase
                    end
                end
                S_SCAN: begin
                    // Issue reads one slot per cycle; compare the slot read last cycle.
                    if (r_idx < CntW'(TABLE_DEPTH)) begin
                        r_idx <= r_idx + CntW'(1);
                    end
                    r_rd_idx <= r_idx[IdxW-1:0];
                    r_rd_ok  <= (r_idx < CntW'(TABLE_DEPTH));
                    if (r_rd_ok) begin
                        if (r_valid[r_rd_idx] && r_rd.win == r_item.window_id &&
                            !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_rd_idx;
                        end
                        if (!r_valid[r_rd_idx] && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                    end
                    if (!(r_idx < CntW'(TABLE_DEPTH)) && !r_rd_ok) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_item.opcode == OpRemove) begin
                        if (out_free) begin
                            if (r_hit) r_valid[r_hit_idx] <= 1'b0;
                            r_out       <= '{kind: KindRemove,
                                             out_window: r_item.window_id,
                                             out_flags_a: '0, out_flags_b: '0,
                                             last: 1'b1};
                            r_state     <= S_IDLE;
                        end
                    end else if (r_hit) begin
                        r_state <= S_RDSLOT;
                    end else if (cachable && r_free_ok) begin
                        r_valid[r_free_idx] <= 1'b1;
                        if (!r_armed) begin
                            r_armed <= 1'b1;
                            r_ticks <= (r_batch == '0) ? TickW'(1) : r_batch;
                        end
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out       <= '{kind: KindChange,
                                         out_window: r_item.window_id,
                                         out_flags_a: r_item.flags_a,
                                         out_flags_b: r_item.flags_b,
                                         last: 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                S_RDSLOT: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    if (cachable) begin
                        if (!r_armed) begin
                            r_armed <= 1'b1;
                            r_ticks <= (r_batch == '0) ? TickW'(1) : r_batch;
                        end
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_valid[r_hit_idx] <= 1'b0;
                        r_out       <= '{kind: KindChange,
                                         out_window: r_item.window_id,
                                         out_flags_a: r_item.flags_a | r_rd.fa,
                                         out_flags_b: r_item.flags_b | r_rd.fb,
                                         last: 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    // Find the next valid slot at or after r_idx and read it.
                    if (r_idx >= CntW'(TABLE_DEPTH)) begin
                        r_state <= S_IDLE;
                    end else if (r_valid[r_idx[IdxW-1:0]]) begin
                        r_rd_idx <= r_idx[IdxW-1:0];
                        r_state  <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + CntW'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_valid[r_rd_idx] <= 1'b0;
                        r_out       <= '{kind: KindChange, out_window: r_rd.win,
                                         out_flags_a: r_rd.fa, out_flags_b: r_rd.fb,
                                         last: ((r_valid & above_mask) == '0)};
                        r_idx       <= r_idx + CntW'(1);
                        r_state     <= S_FLUSH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
